// ----- rtl/ple_pkg.sv -----
// Package with operation codes, status codes and shared types of the list engine.
package ple_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_GET    = 3'd3,
    OP_COUNT  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SHIFT,
    S_OUT
  } state_e;

  localparam logic [31:0] ReadBad = 32'hFFFF_FFFF;

endpackage

// ----- rtl/ple_mem.sv -----
// Element memory with separate write and read ports and a registered read.
module ple_mem #(
  parameter int Depth = 64,
  parameter int Aw    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/positional_list_engine_unit.sv -----
// Top level of the positional list engine: sequencer around one element memory.
// Sequence: every request goes from S_IDLE through S_RD to S_OUT, after which out_valid_o rises;
// insert and delete alternate S_RD (read) and S_SHIFT (write) once per element moved.
// One transaction in flight; the next is taken the cycle after the result is accepted.
// Reset clears the element count and control state; memory contents stay undefined.
module positional_list_engine_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    func_i,
  input  logic [6:0]                    position_i,
  input  logic signed [31:0]            value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic signed [31:0]            read_value_o,
  output logic [6:0]                    length_o
);

  localparam int Aw = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int Cw = $clog2(CAPACITY + 1);

  ple_pkg::state_e state_q, state_d;

  // The captured request, working index and count.
  logic [2:0]  op_q;
  logic [Cw:0] pos_q;
  logic [31:0] val_q;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic [Cw:0] idx_q, idx_d;

  logic [1:0]  st_q, st_d;
  logic [31:0] rd_q, rd_d;
  logic [6:0]  len_q;
  logic        ovalid_q;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic [Cw:0] cnt_x;
  assign cnt_x = {1'b0, cnt_q};

  ple_mem #(.Depth(CAPACITY), .Aw(Aw)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // A new transaction is taken only when idle and the output slot is free.
  assign in_stall_o = (state_q != ple_pkg::S_IDLE) || ovalid_q;

  // Next-state logic. The shift sweep reads the neighbor of entry idx in S_RD
  // and writes it to entry idx in the following S_SHIFT.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ple_pkg::S_IDLE: begin
        if (in_valid_i && !in_stall_o) state_d = ple_pkg::S_RD;
      end
      ple_pkg::S_RD: begin
        state_d = ple_pkg::S_OUT;
        if (st_q == ple_pkg::ST_OK) begin
          if (op_q == ple_pkg::OP_INSERT && idx_q > pos_q) state_d = ple_pkg::S_SHIFT;
          if (op_q == ple_pkg::OP_DELETE && idx_q + 1'b1 < cnt_x) state_d = ple_pkg::S_SHIFT;
        end
      end
      ple_pkg::S_SHIFT: state_d = ple_pkg::S_RD;
      ple_pkg::S_OUT:   state_d = ple_pkg::S_IDLE;
      default:          state_d = ple_pkg::S_IDLE;
    endcase
  end

  // Memory access and bookkeeping.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[Aw-1:0];
    wdata = val_q;
    raddr = idx_q[Aw-1:0];
    idx_d = idx_q;
    cnt_d = cnt_q;
    st_d  = st_q;
    rd_d  = rd_q;
    case (state_q)
      ple_pkg::S_RD: begin
        // Insert reads idx-1, delete reads idx+1, get reads idx.
        if (op_q == ple_pkg::OP_INSERT) raddr = Aw'(idx_q - 1'b1);
        else if (op_q == ple_pkg::OP_DELETE) raddr = Aw'(idx_q + 1'b1);
        if (st_q == ple_pkg::ST_OK) begin
          if (op_q == ple_pkg::OP_INSERT && idx_q == pos_q) begin
            we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          if (op_q == ple_pkg::OP_UPDATE) we = 1'b1;
          if (op_q == ple_pkg::OP_DELETE && !(idx_q + 1'b1 < cnt_x)) cnt_d = cnt_q - 1'b1;
          if (op_q == ple_pkg::OP_CLEAR) cnt_d = '0;
        end
      end
      ple_pkg::S_SHIFT: begin
        we    = 1'b1;
        wdata = rdata;
        if (op_q == ple_pkg::OP_INSERT) idx_d = idx_q - 1'b1;
        else idx_d = idx_q + 1'b1;
      end
      ple_pkg::S_OUT: begin
        if (op_q == ple_pkg::OP_GET && st_q == ple_pkg::ST_OK) rd_d = rdata;
      end
      default: ;
    endcase
  end

  // Request capture and range checks at acceptance.
  logic [Cw:0] pos_in;
  always_comb begin
    pos_in = (Cw + 1 >= 7) ? (Cw+1)'(position_i) : (Cw+1)'(position_i);
  end
  logic pos_big;
  assign pos_big = (Cw + 1 < 7) && (position_i >> (Cw + 1)) != '0;

  // Start index, status and read value of the incoming transaction.
  logic [Cw:0] idx_in;
  logic [1:0]  st_in;
  logic [31:0] rd_in;
  always_comb begin
    idx_in = pos_in;
    st_in  = ple_pkg::ST_OK;
    rd_in  = '0;
    case (func_i)
      ple_pkg::OP_INSERT: begin
        idx_in = cnt_x;
        if (pos_big || pos_in > cnt_x) st_in = ple_pkg::ST_RANGE;
        else if (cnt_x == (Cw+1)'(CAPACITY)) st_in = ple_pkg::ST_FULL;
      end
      ple_pkg::OP_DELETE, ple_pkg::OP_UPDATE: begin
        if (pos_big || pos_in >= cnt_x) st_in = ple_pkg::ST_RANGE;
      end
      ple_pkg::OP_GET: begin
        if (pos_big || pos_in >= cnt_x) begin
          st_in = ple_pkg::ST_RANGE;
          rd_in = ple_pkg::ReadBad;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ple_pkg::S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ple_pkg::S_OUT) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ple_pkg::S_IDLE && in_valid_i && !in_stall_o) begin
      op_q  <= func_i;
      pos_q <= pos_in;
      val_q <= value_i;
      rd_q  <= rd_in;
      st_q  <= st_in;
      idx_q <= idx_in;
    end else begin
      idx_q <= idx_d;
      rd_q  <= rd_d;
    end
    if (state_q == ple_pkg::S_OUT) len_q <= 7'(cnt_q);
  end

  assign out_valid_o  = ovalid_q;
  assign status_o     = st_q;
  assign read_value_o = rd_q;
  assign length_o     = len_q;

endmodule

// ----- rtl/ple_checker.sv -----
// Port-level checker for the positional list engine, bound to the top level.
module ple_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [6:0]  length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(length_o))
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("unused status code");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .length_o   (length_o)
);

// ----- tb/sv/tb_positional_list_engine_unit.sv -----
// Self-checking testbench of the positional list engine with a list scoreboard.
module tb_positional_list_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  length;
  } list_result_t;

  int unsigned mismatch_count = 0;

  // Prints one line per mismatch and keeps the total.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
  endtask

  // The scoreboard mirrors the list and holds the results still to come.
  class list_scoreboard;
    logic [31:0] shadow_list[Cap];
    int unsigned shadow_len;
    list_result_t pending[$];

    function new();
      shadow_len = 0;
    endfunction

    function void note_request(logic [2:0] fn, logic [6:0] pos, logic [31:0] val);
      list_result_t r;
      r.status = ple_pkg::ST_OK;
      r.read_value = '0;
      case (fn)
        ple_pkg::OP_INSERT: begin
          if (pos > shadow_len) r.status = ple_pkg::ST_RANGE;
          else if (shadow_len >= Cap) r.status = ple_pkg::ST_FULL;
          else begin
            for (int i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[pos] = val;
            shadow_len++;
          end
        end
        ple_pkg::OP_DELETE: begin
          if (pos >= shadow_len) r.status = ple_pkg::ST_RANGE;
          else begin
            for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
            shadow_len--;
          end
        end
        ple_pkg::OP_UPDATE: begin
          if (pos >= shadow_len) r.status = ple_pkg::ST_RANGE;
          else shadow_list[pos] = val;
        end
        ple_pkg::OP_GET: begin
          if (pos >= shadow_len) begin
            r.status = ple_pkg::ST_RANGE;
            r.read_value = ple_pkg::ReadBad;
          end else r.read_value = shadow_list[pos];
        end
        ple_pkg::OP_CLEAR: shadow_len = 0;
        default: ;
      endcase
      r.length = shadow_len[6:0];
      pending.push_back(r);
    endfunction

    task check_result(logic [1:0] st, logic [31:0] rd, logic [6:0] len);
      list_result_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", {23'd0, st, len}, 32'd0);
        return;
      end
      w = pending.pop_front();
      if (st !== w.status) report_mismatch("status", st, w.status);
      if (rd !== w.read_value) report_mismatch("read_value", rd, w.read_value);
      if (len !== w.length) report_mismatch("length", len, w.length);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [6:0] position = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [31:0] read_value;
  logic [6:0] length;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  positional_list_engine_unit #(.CAPACITY(Cap)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .position_i(position), .value_i(value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .read_value_o(read_value), .length_o(length)
  );

  list_scoreboard board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  longint unsigned cycle_count = 0;

  // Results are checked at the edge where they are accepted.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall)
      board.check_result(status, read_value, length);
  end

  // The receiver stalls at random, or holds off entirely while a long hold is counted down.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // A run that lasts this long has hung; even all-full shifts stay far below this bound.
  always @(posedge clk) begin
    if (cycle_count > 64'd1500000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one transaction, with random idle cycles first, and waits for acceptance.
  // Valid stays high after acceptance so that a following transaction can go back to back.
  task automatic send_request(input logic [2:0] fn, input logic [6:0] pos,
                              input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    position <= pos;
    value <= val;
    do @(posedge clk); while (in_stall);
    board.note_request(fn, pos, val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Picks a position that is mostly valid, sometimes just past the end or far out.
  function automatic logic [6:0] pick_position(input logic [2:0] fn);
    int unsigned len = board.shadow_len;
    int unsigned roll = $urandom_range(99);
    if (roll < 8) return 7'($urandom_range(127));
    if (roll < 14) return 7'(len);
    if (fn == ple_pkg::OP_INSERT) return 7'($urandom_range(len));
    return (len == 0) ? 7'd0 : 7'($urandom_range(len - 1));
  endfunction

  // Random operation mix; the fill bias steers the list toward full or empty.
  task automatic random_request(input int unsigned fill_bias);
    int unsigned roll = $urandom_range(999);
    logic [2:0] fn;
    if (roll < fill_bias) fn = ple_pkg::OP_INSERT;
    else if (roll < 700) fn = ple_pkg::OP_DELETE;
    else if (roll < 800) fn = ple_pkg::OP_UPDATE;
    else if (roll < 930) fn = ple_pkg::OP_GET;
    else if (roll < 960) fn = ple_pkg::OP_COUNT;
    else if (roll < 975) fn = ple_pkg::OP_CLEAR;
    else fn = 3'($urandom_range(7));
    send_request(fn, pick_position(fn), $urandom());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty list cases, boundary values, every operation, unused codes.
    send_request(ple_pkg::OP_GET, 7'd0, 32'd0);
    send_request(ple_pkg::OP_DELETE, 7'd0, 32'd0);
    send_request(ple_pkg::OP_UPDATE, 7'd0, 32'h1234);
    send_request(ple_pkg::OP_INSERT, 7'd1, 32'd5);
    send_request(ple_pkg::OP_INSERT, 7'd0, 32'h7FFF_FFFF);
    send_request(ple_pkg::OP_INSERT, 7'd0, 32'h8000_0000);
    send_request(ple_pkg::OP_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_request(ple_pkg::OP_INSERT, 7'd1, 32'd0);
    send_request(ple_pkg::OP_GET, 7'd3, 32'd0);
    send_request(ple_pkg::OP_GET, 7'd4, 32'd0);
    send_request(ple_pkg::OP_GET, 7'd127, 32'd0);
    send_request(ple_pkg::OP_UPDATE, 7'd3, 32'hAAAA_5555);
    send_request(ple_pkg::OP_DELETE, 7'd0, 32'd0);
    send_request(ple_pkg::OP_DELETE, 7'd4, 32'd0);
    send_request(ple_pkg::OP_COUNT, 7'd127, 32'hFFFF_FFFF);
    send_request(3'd6, 7'd0, 32'd1);
    send_request(3'd7, 7'd127, 32'hFFFF_FFFF);
    send_request(ple_pkg::OP_CLEAR, 7'd99, 32'd7);
    send_request(ple_pkg::OP_GET, 7'd0, 32'd0);

    // Fill to capacity, then test full-list and at-end rejection.
    for (int i = 0; i < Cap; i++)
      send_request(ple_pkg::OP_INSERT, 7'($urandom_range(i)), $urandom());
    send_request(ple_pkg::OP_INSERT, 7'd64, 32'd1);
    send_request(ple_pkg::OP_INSERT, 7'd65, 32'd1);
    send_request(ple_pkg::OP_GET, 7'd63, 32'd0);
    send_request(ple_pkg::OP_DELETE, 7'd63, 32'd0);
    send_request(ple_pkg::OP_DELETE, 7'd0, 32'd0);

    // Random phases with different idle patterns and fill tendencies.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 71; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 71; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int n = 0; n < 200; n++) random_request((n % 100 < 50) ? 600 : 350);
      // Sender pauses until every outstanding result has been returned.
      wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering transactions.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    for (int n = 0; n < 100; n++) random_request(500);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- positional_list_engine_unit.f -----
rtl/ple_pkg.sv
rtl/ple_mem.sv
rtl/positional_list_engine_unit.sv
rtl/ple_checker.sv
tb/sv/tb_positional_list_engine_unit.sv
